### src/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the crc-8 step for the sensor frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcd_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned HumW   = 17;
  localparam int unsigned TempW  = 19;
  localparam int unsigned IndexW = 3;

  localparam logic [7:0] CrcInit      = 8'hFF;
  localparam logic [7:0] CrcPoly      = 8'h31;
  localparam logic [7:0] BusyMaskRst  = 8'h80;
  localparam logic [7:0] LowNibble    = 8'h0F;

  localparam logic [16:0] HumScale    = 17'd100000;
  localparam logic [17:0] TempScale   = 18'd200000;
  localparam logic signed [TempW-1:0] TempOffset = 19'sd50000;

  // byte positions within a frame
  localparam logic [IndexW-1:0] IdxStatus = 3'd0;
  localparam logic [IndexW-1:0] IdxHumHi  = 3'd1;
  localparam logic [IndexW-1:0] IdxHumMid = 3'd2;
  localparam logic [IndexW-1:0] IdxSplit  = 3'd3;
  localparam logic [IndexW-1:0] IdxTempMid = 3'd4;
  localparam logic [IndexW-1:0] IdxTempLo = 3'd5;
  localparam logic [IndexW-1:0] IdxCrc    = 3'd6;
  localparam logic [IndexW-1:0] IdxIdle   = 3'd7;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBusy   = 2'd1,
    StCrcErr = 2'd2
  } frame_status_e;

  typedef struct packed {
    frame_status_e    status;
    logic [RawW-1:0]  raw_hum;
    logic [RawW-1:0]  temp_raw;
  } frame_res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/sfcd_assembler.sv
// ----------------------------------------------------------------------------
// sfcd_assembler
// Byte tracking, crc-8 accumulation and raw field packing for one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_assembler (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                first_byte_i,
  input  wire logic [7:0]          busy_mask_i,
  output logic                     done_o,
  output sfcd_pkg::frame_res_t     res_o
);
  import sfcd_pkg::*;

  logic [IndexW-1:0] byte_index_q, byte_index_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        status_byte_q, status_byte_d;
  logic [RawW-1:0]   raw_hum_q, raw_hum_d;
  logic [RawW-1:0]   temp_raw_q, temp_raw_d;

  logic [IndexW-1:0] idx;
  logic [7:0]        crc_base;
  logic [RawW-1:0]   hum_base;
  logic [RawW-1:0]   temp_base;
  logic              active;

  always_comb begin
    idx       = first_byte_i ? IdxStatus : byte_index_q;
    crc_base  = first_byte_i ? CrcInit : crc_q;
    hum_base  = first_byte_i ? '0 : raw_hum_q;
    temp_base = first_byte_i ? '0 : temp_raw_q;
    active    = step_i && (idx != IdxIdle);

    byte_index_d  = byte_index_q;
    crc_d         = crc_q;
    status_byte_d = status_byte_q;
    raw_hum_d     = raw_hum_q;
    temp_raw_d    = temp_raw_q;
    done_o        = 1'b0;

    if (active) begin
      raw_hum_d  = hum_base;
      temp_raw_d = temp_base;
      case (idx)
        IdxStatus: begin
          status_byte_d = data_byte_i;
        end
        IdxHumHi: begin
          raw_hum_d[19:12] = data_byte_i;
        end
        IdxHumMid: begin
          raw_hum_d[11:4] = data_byte_i;
        end
        IdxSplit: begin
          raw_hum_d[3:0]    = data_byte_i[7:4];
          temp_raw_d[19:16] = data_byte_i[3:0] & LowNibble[3:0];
        end
        IdxTempMid: begin
          temp_raw_d[15:8] = data_byte_i;
        end
        IdxTempLo: begin
          temp_raw_d[7:0] = data_byte_i;
        end
        default: begin
        end
      endcase

      if (idx == IdxCrc) begin
        byte_index_d = IdxIdle;
        crc_d        = crc_base;
        done_o       = 1'b1;
      end else begin
        byte_index_d = idx + IndexW'(1);
        crc_d        = crc8_step(crc_base, data_byte_i);
      end
    end
  end

  always_comb begin
    res_o.raw_hum  = raw_hum_q;
    res_o.temp_raw = temp_raw_q;
    if ((status_byte_q & busy_mask_i) != 8'h00) begin
      res_o.status = StBusy;
    end else if (crc_q != data_byte_i) begin
      res_o.status = StCrcErr;
    end else begin
      res_o.status = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= IdxIdle;
      crc_q         <= CrcInit;
      status_byte_q <= '0;
      raw_hum_q     <= '0;
      temp_raw_q    <= '0;
    end else begin
      byte_index_q  <= byte_index_d;
      crc_q         <= crc_d;
      status_byte_q <= status_byte_d;
      raw_hum_q     <= raw_hum_d;
      temp_raw_q    <= temp_raw_d;
    end
  end

endmodule

`default_nettype wire

### src/sfcd_scale.sv
// ----------------------------------------------------------------------------
// sfcd_scale
// Constant multiply-and-shift conversion of raw readings to milli units.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_scale (
  input  wire sfcd_pkg::frame_res_t       res_i,
  output logic [sfcd_pkg::HumW-1:0]       humidity_milli_o,
  output logic signed [sfcd_pkg::TempW-1:0] temperature_milli_o
);
  import sfcd_pkg::*;

  logic [RawW+17-1:0] hum_prod;
  logic [RawW+18-1:0] temp_prod;
  logic signed [TempW-1:0] temp_shifted;

  always_comb begin
    hum_prod     = (RawW+17)'(res_i.raw_hum) * (RawW+17)'(HumScale);
    temp_prod    = (RawW+18)'(res_i.temp_raw) * (RawW+18)'(TempScale);
    temp_shifted = signed'({1'b0, temp_prod[RawW+18-1:RawW]});
    if (res_i.status == StOk) begin
      humidity_milli_o    = hum_prod[RawW+17-1:RawW];
      temperature_milli_o = temp_shifted - TempOffset;
    end else begin
      humidity_milli_o    = '0;
      temperature_milli_o = '0;
    end
  end

endmodule

`default_nettype wire

### src/sensor_frame_crc_decode.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decode
// output: the result register loads when the seventh frame byte leaves the input register
// throughput: one byte per cycle, set by the single input and result register pair
// a stalled result holds only the input register; bytes keep flowing when it is taken
// reset: index idle, crc 0xff, raw fields and status byte cleared, busy mask 0x80
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_decode (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          first_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sfcd_pkg::HumW-1:0]          humidity_milli_o,
  output logic signed [sfcd_pkg::TempW-1:0]  temperature_milli_o,
  output logic [1:0]                         frame_status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [7:0]                    cfg_wdata_i
);
  import sfcd_pkg::*;

  logic [7:0] busy_mask_q;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;

  logic       out_valid_q, out_valid_d;
  logic [HumW-1:0]         hum_q;
  logic signed [TempW-1:0] temp_q;
  logic [1:0]              status_q;

  logic       advance;
  logic       in_take;
  logic       step;
  logic       done;
  frame_res_t res;
  logic [HumW-1:0]         hum_c;
  logic signed [TempW-1:0] temp_c;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign step       = s1_valid_q && advance;

  always_comb begin
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = advance ? (step && done) : out_valid_q;
  end

  sfcd_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (s1_byte_q),
    .first_byte_i (s1_first_q),
    .busy_mask_i  (busy_mask_q),
    .done_o       (done),
    .res_o        (res)
  );

  sfcd_scale u_scale (
    .res_i               (res),
    .humidity_milli_o    (hum_c),
    .temperature_milli_o (temp_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_mask_q <= BusyMaskRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        busy_mask_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
    end
    if (step && done) begin
      hum_q    <= hum_c;
      temp_q   <= temp_c;
      status_q <= res.status;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign humidity_milli_o    = hum_q;
  assign temperature_milli_o = temp_q;
  assign frame_status_o      = status_q;

  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_result_from_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a held beat");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != StOk) |-> (hum_q == '0 && temp_q == '0))
    else $error("non-zero readings on a failed frame");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StOk) |-> (hum_q < HumScale))
    else $error("humidity out of range");

endmodule

`default_nettype wire
